/* rtl/core/dtc_pkg.sv */
package dtc_pkg;

  localparam int unsigned CompBits = 16;
  localparam int unsigned WidthBits = 11;
  localparam int unsigned FaceBits = 3;
  // Numerator and divisor span 0 .. 2*|d|, which needs CompBits+2 bits.
  localparam int unsigned NumBits = CompBits + 2;
  localparam int unsigned ProdBits = NumBits + WidthBits;
  localparam int unsigned QuotBits = WidthBits;

  localparam logic [FaceBits-1:0] FaceZero = 3'd0;
  localparam logic [FaceBits-1:0] FacePosX = 3'd1;
  localparam logic [FaceBits-1:0] FacePosY = 3'd2;
  localparam logic [FaceBits-1:0] FacePosZ = 3'd3;
  localparam logic [FaceBits-1:0] FaceNegX = 3'd4;
  localparam logic [FaceBits-1:0] FaceNegY = 3'd5;
  localparam logic [FaceBits-1:0] FaceNegZ = 3'd6;

  localparam logic [WidthBits-1:0] WidthReset = 11'd64;

  typedef struct packed {
    logic signed [CompBits-1:0] dir_x;
    logic signed [CompBits-1:0] dir_y;
    logic signed [CompBits-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [FaceBits-1:0]  face;
    logic [WidthBits-1:0] cell_i;
    logic [WidthBits-1:0] cell_j;
  } cell_t;

  typedef struct packed {
    logic [FaceBits-1:0]  face;
    logic                 zero;
    logic                 sat_i;
    logic                 sat_j;
    logic [WidthBits-1:0] width;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic [NumBits-1:0] num_i;
    logic [NumBits-1:0] num_j;
    logic [NumBits-1:0] den;
  } job_t;

endpackage

/* rtl/core/dtc_front.sv */
module dtc_front import dtc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  dir_t                 dir_i,
  input  logic [WidthBits-1:0] cube_width_i,
  output job_t                 job_o
);

  logic signed [CompBits:0] xs, ys, zs;
  logic [CompBits:0] ax, ay, az;
  logic signed [CompBits:0] d, a1, a2, an1, an2;
  logic [CompBits:0] dm;
  logic signed [NumBits-1:0] n1, n2;
  logic [WidthBits-1:0] w0;
  logic dom_x, dom_y;

  always_comb begin
    xs = (CompBits+1)'(dir_i.dir_x);
    ys = (CompBits+1)'(dir_i.dir_y);
    zs = (CompBits+1)'(dir_i.dir_z);
    ax = xs[CompBits] ? (CompBits+1)'(-xs) : xs;
    ay = ys[CompBits] ? (CompBits+1)'(-ys) : ys;
    az = zs[CompBits] ? (CompBits+1)'(-zs) : zs;
    dom_x = (ax >= ay) && (ax >= az);
    dom_y = (ay >= az);
    if (dom_x) begin
      d = xs; a1 = ys; a2 = zs;
      job_o.meta.face = xs[CompBits] ? FaceNegX : FacePosX;
    end else if (dom_y) begin
      d = ys; a1 = xs; a2 = zs;
      job_o.meta.face = ys[CompBits] ? FaceNegY : FacePosY;
    end else begin
      d = zs; a1 = xs; a2 = ys;
      job_o.meta.face = zs[CompBits] ? FaceNegZ : FacePosZ;
    end
    job_o.meta.zero = (ax == '0) && (ay == '0) && (az == '0);
    if (job_o.meta.zero) begin
      job_o.meta.face = FaceZero;
    end
    dm  = d[CompBits] ? (CompBits+1)'(-d) : d;
    an1 = d[CompBits] ? (CompBits+1)'(-a1) : a1;
    an2 = d[CompBits] ? (CompBits+1)'(-a2) : a2;
    n1 = NumBits'(an1) + NumBits'($signed({1'b0, dm}));
    n2 = NumBits'(an2) + NumBits'($signed({1'b0, dm}));
    job_o.num_i = n1;
    job_o.num_j = n2;
    job_o.den   = {dm, 1'b0};
    job_o.meta.sat_i = (job_o.num_i == job_o.den);
    job_o.meta.sat_j = (job_o.num_j == job_o.den);
    w0 = (cube_width_i == '0) ? WidthBits'(1) : cube_width_i;
    job_o.meta.width = (32'(w0) > 32'(MAX_WIDTH)) ? WidthBits'(MAX_WIDTH) : w0;
  end

endmodule

/* rtl/core/dtc_fifo.sv */
module dtc_fifo import dtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  job_t mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  // The back end never stalls, so the head leaves whenever it is present.
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];
  assign push    = push_i && !full_o;
  assign pop     = valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

/* rtl/core/dtc_div.sv */
module dtc_div import dtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [ProdBits-1:0] dividend_i,
  input  logic [NumBits-1:0]  divisor_i,
  output logic                valid_o,
  output logic [QuotBits-1:0] quot_o
);

  // Restoring division, one quotient bit per stage, most significant first.
  localparam int unsigned RemBits = NumBits + QuotBits;

  logic                v_q   [1:QuotBits];
  logic [RemBits-1:0]  rem_q [1:QuotBits];
  logic [QuotBits-1:0] quo_q [1:QuotBits];
  logic [NumBits-1:0]  dvs_q [1:QuotBits];

  for (genvar s = 0; s < QuotBits; s++) begin : g_stage
    localparam int unsigned K = QuotBits - 1 - s;
    logic                v_in;
    logic [RemBits-1:0]  rem_in;
    logic [QuotBits-1:0] quo_in;
    logic [NumBits-1:0]  dvs_in;
    logic [RemBits-1:0]  sub;
    logic take;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = RemBits'(dividend_i);
      assign quo_in = '0;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign v_in   = v_q[s];
      assign rem_in = rem_q[s];
      assign quo_in = quo_q[s];
      assign dvs_in = dvs_q[s];
    end

    assign sub  = RemBits'(dvs_in) << K;
    assign take = (rem_in >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= take ? rem_in - sub : rem_in;
      quo_q[s+1] <= quo_in | (QuotBits'(take) << K);
      dvs_q[s+1] <= dvs_in;
    end
  end

  assign valid_o = v_q[QuotBits];
  assign quot_o  = quo_q[QuotBits];

endmodule

/* rtl/core/dtc_back.sv */
module dtc_back import dtc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  job_t  job_i,
  output logic  valid_o,
  output cell_t cell_o
);

  logic                mul_v_q;
  logic [ProdBits-1:0] prod_i_q, prod_j_q;
  logic [NumBits-1:0]  den_q;
  meta_t               meta_q [QuotBits+1];
  logic                div_v_i, div_v_j;
  logic [QuotBits-1:0] quot_i, quot_j;
  logic                out_v_q;
  cell_t               out_q;
  logic [WidthBits-1:0] half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      mul_v_q <= valid_i;
      out_v_q <= div_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_i_q  <= ProdBits'(job_i.num_i) * ProdBits'(job_i.meta.width);
    prod_j_q  <= ProdBits'(job_i.num_j) * ProdBits'(job_i.meta.width);
    den_q     <= job_i.den;
    meta_q[0] <= job_i.meta;
    for (int s = 0; s < QuotBits; s++) begin
      meta_q[s+1] <= meta_q[s];
    end
  end

  dtc_div u_div_i (
    .clk_i, .rst_ni, .valid_i(mul_v_q), .dividend_i(prod_i_q), .divisor_i(den_q),
    .valid_o(div_v_i), .quot_o(quot_i)
  );

  dtc_div u_div_j (
    .clk_i, .rst_ni, .valid_i(mul_v_q), .dividend_i(prod_j_q), .divisor_i(den_q),
    .valid_o(div_v_j), .quot_o(quot_j)
  );

  assign half = (meta_q[QuotBits].width >> 1) + WidthBits'(1);

  always_ff @(posedge clk_i) begin
    out_q.face <= meta_q[QuotBits].face;
    if (meta_q[QuotBits].zero) begin
      out_q.cell_i <= half;
      out_q.cell_j <= half;
    end else begin
      out_q.cell_i <= meta_q[QuotBits].sat_i ? meta_q[QuotBits].width
                                             : quot_i + WidthBits'(1);
      out_q.cell_j <= (meta_q[QuotBits].sat_j || !div_v_j) ? meta_q[QuotBits].width
                                                          : quot_j + WidthBits'(1);
    end
  end

  assign valid_o = out_v_q;
  assign cell_o  = out_q;

endmodule

/* rtl/core/direction_to_cube_cell_top.sv */
// Direction to cube cell mapper.
// A direction (dir_i, three signed 16-bit components) is transferred at a
// rising clock edge where start_i is high and busy_o is low. The block picks
// the dominant axis as the cube face and computes the two cell indices on
// that face from the ratios of the other components to the dominant one.
// Each result (cell_o: face, cell_i, cell_j) appears on the result ports for
// exactly one cycle with result_valid_o high; the receiver cannot stall it.
// Results come out in the order the directions went in.
// From the accepting edge a direction passes through the input queue, the
// multiply stage, the pipelined restoring dividers (one quotient bit per
// stage) and the output register before its result is transferred.
// Throughput is one direction per cycle; the dividers are fully pipelined,
// so busy_o stays low in normal operation.
// The user must write the width register with cfg_we_i and cfg_wdata_i only
// while the block is idle; the block does not enforce this. Reset sets it
// to 64 and empties the queue and pipeline.
module direction_to_cube_cell_top import dtc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  dir_t                 dir_i,
  input  logic                 cfg_we_i,
  input  logic [WidthBits-1:0] cfg_wdata_i,
  output logic                 result_valid_o,
  output cell_t                cell_o
);

  logic [WidthBits-1:0] cube_width_q;
  job_t front_job, head_job;
  logic head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_width_q <= WidthReset;
    end else if (cfg_we_i) begin
      cube_width_q <= cfg_wdata_i;
    end
  end

  // The front end classifies the direction in the accepting cycle.
  dtc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .dir_i, .cube_width_i(cube_width_q), .job_o(front_job)
  );

  // The queue decouples acceptance from the arithmetic back end.
  dtc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(start_i), .job_i(front_job), .full_o(busy_o),
    .valid_o(head_valid), .job_o(head_job)
  );

  dtc_back u_back (
    .clk_i, .rst_ni, .valid_i(head_valid), .job_i(head_job),
    .valid_o(result_valid_o), .cell_o
  );

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (cell_o.face <= FaceNegZ))
    else $error("face code out of range");

  a_cell_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (cell_o.cell_i != '0 && cell_o.cell_j != '0))
    else $error("cell index of zero");

  a_zero_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && cell_o.face == FaceZero) |-> (cell_o.cell_i == cell_o.cell_j))
    else $error("zero vector not centered");

endmodule
